// File: design/stk_pkg.sv
// Package with character codes, item kinds and widths for the statement tokenizer.
`default_nettype none

package stk_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CAP_W  = 13;
    localparam int unsigned LEN_W  = 12;
    localparam int unsigned CONS_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd512;
    localparam logic [CAP_W-1:0] CAP_MAX   = 13'd4096;

    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    typedef enum logic {
        KIND_CHAR = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

endpackage

`default_nettype wire

// File: design/statement_tokenizer.sv
// Top level of the statement tokenizer: per-byte state update and registered result.
//
//   channel   direction  handshake                 payload
//   in        request    i_in_valid / o_in_ready   i_data_byte
//   out       result     o_out_valid / i_out_ready o_out_kind, o_out_char, o_stmt_length,
//                                                  o_consumed
//   cfg       write      i_cfg_we                  i_cfg_wdata (capacity)
//
// One request is taken per cycle while the output is not stalled; its result, if any,
// appears in the cycle after it is taken. The only path from request to result is the flag update and a 12-bit compare
// against the character limit held in a register.
// Reset is synchronous and active low; it clears the flags, counters and output valid.
// A request is still taken while the output is stalled if the waiting result leaves
// in the same cycle.
`default_nettype none

module statement_tokenizer #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [stk_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [stk_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_out_kind,
    output logic [stk_pkg::BYTE_W-1:0]         o_out_char,
    output logic [stk_pkg::LEN_W-1:0]          o_stmt_length,
    output logic [stk_pkg::CONS_W-1:0]         o_consumed
);

    localparam int unsigned EXT_W = (COUNT_WIDTH > stk_pkg::CONS_W) ? COUNT_WIDTH
                                                                    : stk_pkg::CONS_W;

    logic                        r_line_start, n_line_start;
    logic                        r_in_comment, n_in_comment;
    logic                        r_escape, n_escape;
    logic [stk_pkg::LEN_W-1:0]   r_char_count, n_char_count;
    logic [COUNT_WIDTH-1:0]      r_byte_count, n_byte_count;
    logic [stk_pkg::LEN_W-1:0]   r_char_limit, n_char_limit;

    logic                        r_out_valid;
    stk_pkg::t_kind              r_out_kind, n_out_kind;
    logic [stk_pkg::BYTE_W-1:0]  r_out_char, n_out_char;
    logic [stk_pkg::LEN_W-1:0]   r_stmt_length, n_stmt_length;
    logic [stk_pkg::CONS_W-1:0]  r_consumed, n_consumed;

    logic                        accept;
    logic                        is_break;
    logic                        want_char;
    logic [stk_pkg::BYTE_W-1:0]  char_val;
    logic                        has_result;
    logic [COUNT_WIDTH-1:0]      inc_count;
    logic [EXT_W-1:0]            count_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_break   = (i_data_byte == stk_pkg::CH_CR) || (i_data_byte == stk_pkg::CH_LF);

    // Clamp the capacity to 1..4096 and keep capacity minus one.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_char_limit = '0;
        end else if (i_cfg_wdata > stk_pkg::CAP_MAX) begin
            n_char_limit = stk_pkg::LEN_W'(stk_pkg::CAP_MAX - 13'd1);
        end else begin
            n_char_limit = stk_pkg::LEN_W'(i_cfg_wdata - 13'd1);
        end
    end

    always_comb begin
        inc_count = (r_byte_count == '1) ? r_byte_count : r_byte_count + 1'b1;
        count_ext = EXT_W'(inc_count);

        n_line_start  = r_line_start;
        n_in_comment  = r_in_comment;
        n_escape      = r_escape;
        n_char_count  = r_char_count;
        n_byte_count  = inc_count;
        want_char     = 1'b0;
        char_val      = i_data_byte;
        has_result    = 1'b0;
        n_out_kind    = stk_pkg::KIND_CHAR;
        n_out_char    = '0;
        n_stmt_length = '0;
        n_consumed    = '0;

        if (r_in_comment) begin
            if (is_break) begin
                n_in_comment = 1'b0;
                n_line_start = 1'b1;
            end
        end else if (r_escape) begin
            n_escape  = 1'b0;
            want_char = 1'b1;
        end else if (i_data_byte == stk_pkg::CH_BSL) begin
            n_escape = 1'b1;
        end else if (r_line_start && i_data_byte == stk_pkg::CH_HASH) begin
            n_in_comment = 1'b1;
            n_line_start = 1'b0;
        end else if (r_line_start && (i_data_byte == stk_pkg::CH_SPACE ||
                                      i_data_byte == stk_pkg::CH_TAB)) begin
            n_line_start = 1'b1;
        end else if (is_break) begin
            want_char    = !r_line_start;
            char_val     = stk_pkg::CH_SPACE;
            n_line_start = 1'b1;
        end else if (i_data_byte == stk_pkg::CH_SEMI) begin
            has_result    = 1'b1;
            n_out_kind    = stk_pkg::KIND_END;
            n_stmt_length = r_char_count;
            if (count_ext > EXT_W'(17'h0FFFF)) begin
                n_consumed = '1;
            end else begin
                n_consumed = count_ext[stk_pkg::CONS_W-1:0];
            end
            n_line_start  = 1'b1;
            n_in_comment  = 1'b0;
            n_escape      = 1'b0;
            n_char_count  = '0;
            n_byte_count  = '0;
        end else begin
            n_line_start = 1'b0;
            want_char    = 1'b1;
        end

        if (want_char && (r_char_count < r_char_limit)) begin
            has_result   = 1'b1;
            n_out_char   = char_val;
            n_char_count = r_char_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_start <= 1'b1;
            r_in_comment <= 1'b0;
            r_escape     <= 1'b0;
            r_char_count <= '0;
            r_byte_count <= '0;
            r_char_limit <= stk_pkg::LEN_W'(stk_pkg::CAP_RESET - 13'd1);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_char_limit <= n_char_limit;
            end
            if (accept) begin
                r_line_start <= n_line_start;
                r_in_comment <= n_in_comment;
                r_escape     <= n_escape;
                r_char_count <= n_char_count;
                r_byte_count <= n_byte_count;
                r_out_valid  <= has_result;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && has_result) begin
            r_out_kind    <= n_out_kind;
            r_out_char    <= n_out_char;
            r_stmt_length <= n_stmt_length;
            r_consumed    <= n_consumed;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_out_char    = r_out_char;
    assign o_stmt_length = r_stmt_length;
    assign o_consumed    = r_consumed;

endmodule

`default_nettype wire

// File: design/stk_checker.sv
// Port-level checker for the statement tokenizer and its bind statement.
`default_nettype none

module stk_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_out_kind,
    input wire logic [stk_pkg::BYTE_W-1:0]    o_out_char,
    input wire logic [stk_pkg::LEN_W-1:0]     o_stmt_length,
    input wire logic [stk_pkg::CONS_W-1:0]    o_consumed
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("request refused while output can move");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_char) &&
                                           $stable(o_out_kind) && $stable(o_consumed)))
        else $error("stalled result changed");

    a_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind == stk_pkg::KIND_CHAR) |->
            (o_stmt_length == '0 && o_consumed == '0))
        else $error("character result carries counts");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind == stk_pkg::KIND_END) |->
            (o_out_char == '0 && o_consumed != '0))
        else $error("end result malformed");

endmodule

bind statement_tokenizer stk_checker u_stk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_kind    (o_out_kind),
    .o_out_char    (o_out_char),
    .o_stmt_length (o_stmt_length),
    .o_consumed    (o_consumed)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the statement tokenizer with a built-in behavioral predictor.
`default_nettype none

module testbench;

    localparam int COUNT_W = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        stk_pkg::t_kind                  kind;
        logic [stk_pkg::BYTE_W-1:0]      ch;
        logic [stk_pkg::LEN_W-1:0]       len;
        logic [stk_pkg::CONS_W-1:0]      consumed;
    } t_token;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [stk_pkg::CAP_W-1:0]     i_cfg_wdata;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [stk_pkg::BYTE_W-1:0]    i_data_byte;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_out_kind;
    logic [stk_pkg::BYTE_W-1:0]    o_out_char;
    logic [stk_pkg::LEN_W-1:0]     o_stmt_length;
    logic [stk_pkg::CONS_W-1:0]    o_consumed;

    t_token expected_tokens[$];
    int     mismatch_count = 0;
    int     bytes_sent = 0;
    int     stall_cycles = 0;
    int     hold_asked = 0;
    int     hold_done = 0;
    bit     no_idle = 1'b0;

    logic [stk_pkg::CAP_W-1:0]   capacity_reg;
    logic                        at_line_start;
    logic                        in_comment;
    logic                        escape_pending;
    logic [stk_pkg::LEN_W-1:0]   char_tally;
    logic [COUNT_W-1:0]          byte_tally;

    statement_tokenizer #(.COUNT_WIDTH(COUNT_W)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_kind    (o_out_kind),
        .o_out_char    (o_out_char),
        .o_stmt_length (o_stmt_length),
        .o_consumed    (o_consumed)
    );

    always #4 i_clk = ~i_clk;

    task automatic clear_statement_state();
        at_line_start  = 1'b1;
        in_comment     = 1'b0;
        escape_pending = 1'b0;
        char_tally     = '0;
        byte_tally     = '0;
    endtask

    task automatic emit_char(input logic [stk_pkg::BYTE_W-1:0] ch);
        logic [stk_pkg::CAP_W-1:0] cap_eff;
        logic [stk_pkg::LEN_W-1:0] char_limit;
        t_token tok;
        cap_eff = capacity_reg;
        if (cap_eff == '0) begin
            cap_eff = 13'd1;
        end else if (cap_eff > stk_pkg::CAP_MAX) begin
            cap_eff = stk_pkg::CAP_MAX;
        end
        char_limit = stk_pkg::LEN_W'(cap_eff - 13'd1);
        if (char_tally < char_limit) begin
            char_tally = char_tally + 1'b1;
            tok.kind = stk_pkg::KIND_CHAR;
            tok.ch = ch;
            tok.len = '0;
            tok.consumed = '0;
            expected_tokens.push_back(tok);
        end
    endtask

    task automatic tokenize_byte(input logic [stk_pkg::BYTE_W-1:0] b);
        logic is_break;
        t_token tok;
        is_break = (b == stk_pkg::CH_CR) || (b == stk_pkg::CH_LF);
        if (byte_tally != '1) begin
            byte_tally = byte_tally + 1'b1;
        end
        if (in_comment) begin
            if (is_break) begin
                in_comment = 1'b0;
                at_line_start = 1'b1;
            end
        end else if (escape_pending) begin
            escape_pending = 1'b0;
            emit_char(b);
        end else if (b == stk_pkg::CH_BSL) begin
            escape_pending = 1'b1;
        end else if (at_line_start && b == stk_pkg::CH_HASH) begin
            in_comment = 1'b1;
            at_line_start = 1'b0;
        end else if (at_line_start && (b == stk_pkg::CH_SPACE || b == stk_pkg::CH_TAB)) begin
        end else if (is_break) begin
            if (!at_line_start) begin
                emit_char(stk_pkg::CH_SPACE);
            end
            at_line_start = 1'b1;
        end else if (b == stk_pkg::CH_SEMI) begin
            tok.kind = stk_pkg::KIND_END;
            tok.ch = '0;
            tok.len = char_tally;
            tok.consumed = (byte_tally > COUNT_W'(16'hFFFF)) ? 16'hFFFF
                                                             : stk_pkg::CONS_W'(byte_tally);
            expected_tokens.push_back(tok);
            clear_statement_state();
        end else begin
            at_line_start = 1'b0;
            emit_char(b);
        end
    endtask

    task automatic send_byte(input logic [stk_pkg::BYTE_W-1:0] b);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        tokenize_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    function automatic logic [stk_pkg::BYTE_W-1:0] random_byte();
        return stk_pkg::BYTE_W'($urandom_range(255));
    endfunction

    function automatic logic [stk_pkg::BYTE_W-1:0] plain_byte();
        logic [stk_pkg::BYTE_W-1:0] b;
        b = stk_pkg::CH_BSL;
        while (b == stk_pkg::CH_BSL || b == stk_pkg::CH_SEMI ||
               b == stk_pkg::CH_CR || b == stk_pkg::CH_LF) begin
            b = random_byte();
        end
        return b;
    endfunction

    function automatic logic [stk_pkg::BYTE_W-1:0] comment_byte();
        logic [stk_pkg::BYTE_W-1:0] b;
        b = stk_pkg::CH_CR;
        while (b == stk_pkg::CH_CR || b == stk_pkg::CH_LF) begin
            b = random_byte();
        end
        return b;
    endfunction

    task automatic send_line_break();
        case ($urandom_range(2))
            0: send_byte(stk_pkg::CH_CR);
            1: send_byte(stk_pkg::CH_LF);
            default: begin
                send_byte(stk_pkg::CH_CR);
                send_byte(stk_pkg::CH_LF);
            end
        endcase
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [stk_pkg::CAP_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        capacity_reg = value;
    endtask

    task automatic test_directed();
        // Covers leading blanks, repeated line breaks, comments holding a
        // semicolon and a backslash, an escaped hash, semicolon, backslash and line feed, and byte extremes.
        send_text(" \tab\n\r#x;\\\n\\# \\;\\\\\\\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(stk_pkg::CH_SEMI);
    endtask

    task automatic test_output_hold_off();
        hold_asked++;
        repeat (40) send_byte(plain_byte());
        send_byte(stk_pkg::CH_SEMI);
    endtask

    task automatic test_capacity_extremes();
        for (int cap = 0; cap <= 3; cap++) begin
            write_capacity(stk_pkg::CAP_W'(cap));
            send_text("ab\ncd");
            send_byte(stk_pkg::CH_SEMI);
        end
        write_capacity(stk_pkg::CAP_MAX + 1'b1);
        send_text("xy");
        send_byte(stk_pkg::CH_SEMI);
        write_capacity('1);
        send_text("xy");
        send_byte(stk_pkg::CH_SEMI);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (60) send_byte(plain_byte());
        send_byte(stk_pkg::CH_SEMI);
        no_idle = 1'b0;
    endtask

    task automatic send_statement();
        int lines;
        lines = $urandom_range(1, 3);
        for (int l = 0; l < lines; l++) begin
            repeat ($urandom_range(0, 2)) begin
                send_byte($urandom_range(1) ? stk_pkg::CH_SPACE : stk_pkg::CH_TAB);
            end
            if ($urandom_range(99) < 15) begin
                send_byte(stk_pkg::CH_HASH);
                repeat ($urandom_range(0, 6)) send_byte(comment_byte());
                send_line_break();
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    if ($urandom_range(99) < 10) begin
                        send_byte(stk_pkg::CH_BSL);
                        send_byte(random_byte());
                    end else begin
                        send_byte(plain_byte());
                    end
                end
                if (l < lines - 1 || $urandom_range(1)) begin
                    send_line_break();
                end
            end
        end
        send_byte(stk_pkg::CH_SEMI);
    endtask

    task automatic test_random_statements(input logic [stk_pkg::CAP_W-1:0] cap,
                                          input int wanted);
        int start;
        write_capacity(cap);
        start = bytes_sent;
        while (bytes_sent - start < wanted) begin
            if ($urandom_range(99) < 80) begin
                send_statement();
            end else begin
                repeat ($urandom_range(1, 12)) send_byte(random_byte());
            end
        end
    endtask

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_tokens
        t_token want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_tokens.size() == 0) begin
                report("unexpected request result", '0, 32'({o_out_kind, o_out_char}));
            end else begin
                want = expected_tokens.pop_front();
                if (o_out_kind !== want.kind) begin
                    report("out_kind", 32'(want.kind), 32'(o_out_kind));
                end
                if (o_out_char !== want.ch) begin
                    report("out_char", 32'(want.ch), 32'(o_out_char));
                end
                if (o_stmt_length !== want.len) begin
                    report("stmt_length", 32'(want.len), 32'(o_stmt_length));
                end
                if (o_consumed !== want.consumed) begin
                    report("consumed", 32'(want.consumed), 32'(o_consumed));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL statement_tokenizer");
                $finish;
            end
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_done = hold_asked;
            end
            i_out_ready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        capacity_reg = stk_pkg::CAP_RESET;
        clear_statement_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_output_hold_off();
        test_capacity_extremes();
        test_back_to_back();
        test_random_statements(stk_pkg::CAP_W'($urandom_range(1, 16)), 200);
        test_random_statements(stk_pkg::CAP_W'($urandom_range(17, 600)), 200);
        test_random_statements(stk_pkg::CAP_W'($urandom_range(0, 8191)), 180);
        test_random_statements(stk_pkg::CAP_RESET, 180);
        drain_results();

        if (mismatch_count == 0) begin
            $display("PASS statement_tokenizer");
        end else begin
            $display("FAIL statement_tokenizer");
        end
        $finish;
    end

endmodule

`default_nettype wire
